@@ hw/rtl/ctfc_pkg.sv @@
// shared types, constants and functions for the frame trailer crc check
// no dependencies
package ctfc_pkg;

    localparam int TRAILER_LEN = 4;
    localparam int FILL_W      = $clog2(TRAILER_LEN + 1);
    localparam int IDX_W       = $clog2(TRAILER_LEN);

    localparam logic [15:0] CRC_POLY       = 16'hA001;
    localparam logic [15:0] CRC_INIT_RESET = 16'hFFFF;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } ctfc_item_t;

    typedef struct packed {
        logic [FILL_W-1:0] fill;
    } ctfc_status_t;

    // one byte through the reflected crc, bit by bit
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    // uppercase ascii hex digit of one nibble
    function automatic logic [7:0] hex_upper(input logic [3:0] nib);
        logic [7:0] ch;
        if (nib < 4'd10)
        begin
            ch = 8'h30 + {4'h0, nib};
        end
        else
        begin
            ch = 8'h41 + {4'h0, nib} - 8'd10;
        end
        return ch;
    endfunction

endpackage

@@ hw/rtl/ctfc_in_stage.sv @@
// input register stage: holds one accepted character until the core takes it
// depends on ctfc_pkg
module ctfc_in_stage
    import ctfc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output logic       item_valid,
    output ctfc_item_t item,
    input  logic       item_take
);

    logic       valid_reg;
    logic       valid_next;
    ctfc_item_t item_reg;

    assign in_stall   = valid_reg && !item_take;
    assign valid_next = in_stall ? valid_reg : in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            item_reg.data <= data_byte;
            item_reg.last <= last_byte;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

@@ hw/rtl/ctfc_frame_core.sv @@
// frame state (crc, trailer delay line, fill count) and the result register
// depends on ctfc_pkg
module ctfc_frame_core
    import ctfc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic [15:0]  crc_init,
    input  logic         item_valid,
    input  ctfc_item_t   item,
    output logic         item_take,
    output logic         out_valid,
    input  logic         out_stall,
    output logic [15:0]  crc_value,
    output logic         crc_match,
    output logic         short_frame,
    output ctfc_status_t status
);

    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [15:0]       crc_reg, crc_next;
    logic [7:0]        dly_reg [TRAILER_LEN];
    logic [7:0]        dly_next [TRAILER_LEN];

    logic        out_valid_reg, out_valid_next;
    logic [15:0] crc_value_reg;
    logic        crc_match_reg, short_frame_reg;

    logic        out_free;
    logic        full;
    logic [15:0] crc_base;
    logic [15:0] crc_upd;
    logic [7:0]  dly_upd [TRAILER_LEN];
    logic [FILL_W-1:0] fill_upd;
    logic        res_short;
    logic        res_match;
    logic        res_load;

    assign out_free  = !out_valid_reg || !out_stall;
    assign item_take = item_valid && (!item.last || out_free);
    assign res_load  = item_take && item.last;
    assign full      = (fill_reg >= FILL_W'(TRAILER_LEN));
    assign crc_base  = (fill_reg == '0) ? crc_init : crc_reg;

    always_comb
    begin
        crc_upd  = crc_base;
        fill_upd = fill_reg;
        for (int i = 0; i < TRAILER_LEN; i++)
        begin
            dly_upd[i] = dly_reg[i];
        end
        if (full)
        begin
            // oldest held character leaves the delay line into the crc
            crc_upd = crc_byte(crc_base, dly_reg[0]);
            for (int i = 0; i < TRAILER_LEN - 1; i++)
            begin
                dly_upd[i] = dly_reg[i + 1];
            end
            dly_upd[TRAILER_LEN - 1] = item.data;
        end
        else
        begin
            dly_upd[fill_reg[IDX_W-1:0]] = item.data;
            fill_upd = fill_reg + FILL_W'(1);
        end
    end

    always_comb
    begin
        res_short = (fill_upd < FILL_W'(TRAILER_LEN));
        res_match = !res_short;
        for (int i = 0; i < TRAILER_LEN; i++)
        begin
            if (dly_upd[i] != hex_upper(crc_upd[15 - 4 * i -: 4]))
            begin
                res_match = 1'b0;
            end
        end
    end

    always_comb
    begin
        fill_next = fill_reg;
        crc_next  = crc_reg;
        for (int i = 0; i < TRAILER_LEN; i++)
        begin
            dly_next[i] = dly_reg[i];
        end
        if (item_take)
        begin
            if (item.last)
            begin
                // frame done, start clean
                fill_next = '0;
                crc_next  = crc_init;
                for (int i = 0; i < TRAILER_LEN; i++)
                begin
                    dly_next[i] = 8'h00;
                end
            end
            else
            begin
                fill_next = fill_upd;
                crc_next  = crc_upd;
                for (int i = 0; i < TRAILER_LEN; i++)
                begin
                    dly_next[i] = dly_upd[i];
                end
            end
        end
    end

    assign out_valid_next = res_load ? 1'b1 : (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            crc_reg       <= CRC_INIT_RESET;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < TRAILER_LEN; i++)
            begin
                dly_reg[i] <= 8'h00;
            end
        end
        else
        begin
            fill_reg      <= fill_next;
            crc_reg       <= crc_next;
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < TRAILER_LEN; i++)
            begin
                dly_reg[i] <= dly_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            crc_value_reg   <= crc_upd;
            crc_match_reg   <= res_match;
            short_frame_reg <= res_short;
        end
    end

    assign out_valid   = out_valid_reg;
    assign crc_value   = crc_value_reg;
    assign crc_match   = crc_match_reg;
    assign short_frame = short_frame_reg;
    assign status.fill = fill_reg;

endmodule

@@ hw/rtl/crc16_ascii_trailer_frame_check.sv @@
// top level of the frame trailer crc check
// depends on ctfc_pkg, ctfc_in_stage and ctfc_frame_core
//
// Takes one frame character per transfer and, on the character flagged last, returns one
// result: the reflected crc-16 (poly 0xA001) of all characters before the four-character
// trailer, whether the trailer spells that crc as four uppercase hex digits (high nibble
// first, case-sensitive), and a short-frame flag for frames under four characters (which
// then report no match and the start value as crc). One character is accepted every
// cycle, except that a last character waits in the input register, and the input stalls,
// while an earlier result is still held by a stalled sink. A result is loaded into the
// output register when the core takes its last character from the input register; the crc
// byte step runs between the input register and the result register. crc_init is
// sampled at the first character of each frame, so a write takes effect from the next
// frame; the config port is always ready.
module crc16_ascii_trailer_frame_check
    import ctfc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] crc_value,
    output logic        crc_match,
    output logic        short_frame
);

    logic [15:0]  crc_init_reg;
    logic         item_valid;
    ctfc_item_t   item;
    logic         item_take;
    ctfc_status_t status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_init_reg <= CRC_INIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            crc_init_reg <= cfg_data;
        end
    end

    ctfc_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    ctfc_frame_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .crc_init    (crc_init_reg),
        .item_valid  (item_valid),
        .item        (item),
        .item_take   (item_take),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .crc_value   (crc_value),
        .crc_match   (crc_match),
        .short_frame (short_frame),
        .status      (status)
    );

    // a short frame never reports a match
    a_short_no_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && short_frame |-> !crc_match)
        else $error("short frame reported as matching");

    // input only backs up when a finished result is held by the sink
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall && item_valid && item.last)
        else $error("input stalled without a blocked result");

    // delay line fill never passes the trailer length
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        status.fill <= FILL_W'(TRAILER_LEN))
        else $error("trailer fill count out of range");

    // a last character taken always yields a result next cycle
    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        item_take && item.last |=> out_valid)
        else $error("last character taken without a result");

endmodule
